FILE: rtl/mrrd_pkg.sv
// ----------------------------------------------------------------------------
// mrrd_pkg
// Shared types and constants of the multicore round-robin dispatcher.
// ----------------------------------------------------------------------------
package mrrd_pkg;

   localparam int MAX_CORES_DEF   = 4;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int KIND_W  = 3;
   localparam int JOB_W   = 8;
   localparam int LEN_W   = 16;
   localparam int QNT_W   = 16;
   localparam int ECORE_W = 2;
   localparam int FREE_W  = 3;
   localparam int QCNT_W  = 5;
   localparam int ACT_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_EN  = 2'd3;

   localparam logic [KIND_W-1:0] EV_ACCEPTED   = 3'd0;
   localparam logic [KIND_W-1:0] EV_REJECTED   = 3'd1;
   localparam logic [KIND_W-1:0] EV_FINISHED   = 3'd2;
   localparam logic [KIND_W-1:0] EV_DISPATCHED = 3'd3;
   localparam logic [KIND_W-1:0] EV_PREEMPTED  = 3'd4;
   localparam logic [KIND_W-1:0] EV_TICK_DONE  = 3'd5;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load_item;   // capture input item
      logic do_add;      // admission test and push
      logic do_assign;   // retire / dispatch on current core
      logic do_exec;     // execute one instruction on current core
      logic core_first;  // reset core pointer
      logic core_next;   // advance core pointer
      logic emit_tick;   // emit tick done
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic op_tick;
      logic run_en;
      logic core_last;   // current core is last active one
      logic no_active;
      logic emit_busy;   // an emitted result is still held
   } sts_type;

endpackage

FILE: rtl/mrrd_datapath.sv
// ----------------------------------------------------------------------------
// mrrd_datapath
// Ready queue memory, core registers, config registers and result register.
// ----------------------------------------------------------------------------
module mrrd_datapath #(
   parameter int MAX_CORES   = mrrd_pkg::MAX_CORES_DEF,
   parameter int QUEUE_DEPTH = mrrd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mrrd_pkg::cmd_type                cmd,
   output mrrd_pkg::sts_type                sts,
   input  logic                             item_op,
   input  logic [mrrd_pkg::JOB_W-1:0]       item_job,
   input  logic [mrrd_pkg::LEN_W-1:0]       item_len,
   input  logic                             csr_we,
   input  logic [mrrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mrrd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [mrrd_pkg::KIND_W-1:0]      out_kind,
   output logic [mrrd_pkg::JOB_W-1:0]       out_job,
   output logic [mrrd_pkg::ECORE_W-1:0]     out_core,
   output logic [mrrd_pkg::FREE_W-1:0]      out_free,
   output logic [mrrd_pkg::QCNT_W-1:0]      out_qcnt,
   output logic                             out_last
);
   localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int C_W  = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam int CC_W = $clog2(MAX_CORES + 1);
   localparam int JW   = mrrd_pkg::JOB_W;
   localparam int LW   = mrrd_pkg::LEN_W;
   localparam int QW   = mrrd_pkg::QNT_W;

   // config
   logic          rr_mode_ff;
   logic [QW-1:0] quantum_ff;
   logic [mrrd_pkg::ACT_W-1:0] active_ff;
   logic          run_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_mode_ff <= 1'b0;
         quantum_ff <= QW'(1);
         active_ff  <= mrrd_pkg::ACT_W'(4);
         run_en_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            mrrd_pkg::CSR_RR_MODE: rr_mode_ff <= csr_wdata[0];
            mrrd_pkg::CSR_QUANTUM: quantum_ff <= csr_wdata[QW-1:0];
            mrrd_pkg::CSR_ACTIVE:  active_ff  <= csr_wdata[mrrd_pkg::ACT_W-1:0];
            mrrd_pkg::CSR_RUN_EN:  run_en_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // item
   logic          op_ff;
   logic [JW-1:0] id_ff;
   logic [LW-1:0] len_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff  <= item_op;
         id_ff  <= item_job;
         len_ff <= item_len;
      end
   end

   // active core count, saturated
   logic [CC_W:0] act_sat;
   always_comb begin
      if (32'(active_ff) > 32'(MAX_CORES)) act_sat = (CC_W+1)'(MAX_CORES);
      else act_sat = (CC_W+1)'(active_ff);
   end

   // queue memory, registered read of head entry
   logic [JW+LW-1:0] q_mem [QUEUE_DEPTH];
   logic [JW+LW-1:0] q_rd_ff;
   logic [QA_W-1:0]  head_ff, tail_ff, head_in, tail_in;
   logic [QC_W-1:0]  qcnt_ff, qcnt_in;
   logic             q_we;
   logic [JW+LW-1:0] q_wdata;

   function automatic logic [QA_W-1:0] nxt(input logic [QA_W-1:0] i);
      if (32'(i) + 1 >= QUEUE_DEPTH) return '0;
      return i + QA_W'(1);
   endfunction

   // cores
   logic          busy_ff [MAX_CORES];
   logic [JW-1:0] cjob_ff [MAX_CORES];
   logic [LW-1:0] left_ff [MAX_CORES];
   logic [QW-1:0] slice_ff[MAX_CORES];
   logic [C_W-1:0] cur_ff;
   logic [CC_W-1:0] run_cnt, free_cnt;  // running / free (for pre-state)

   always_comb begin
      run_cnt = '0;
      for (int c = 0; c < MAX_CORES; c++)
         if (busy_ff[c] && left_ff[c] != '0) run_cnt = run_cnt + CC_W'(1);
      free_cnt = CC_W'(MAX_CORES) - run_cnt;
   end

   // per-step next-state
   logic          busy_n;
   logic [JW-1:0] cjob_n;
   logic [LW-1:0] left_n;
   logic [QW-1:0] slice_n;
   logic          ev_v;
   logic [mrrd_pkg::KIND_W-1:0] ev_k;
   logic [JW-1:0] ev_j;
   logic [CC_W-1:0] free_after;
   logic          fin, disp, expired;
   logic [LW-1:0] left_dec;
   // finished and dispatched in one step: emit two results, second held here
   logic          pend_ff, pend_in;
   logic [JW-1:0] pend_job_ff, pend_job_in;
   logic [CC_W-1:0] pend_free_ff, pend_free_in;
   logic [QC_W-1:0] pend_q_ff, pend_q_in;

   always_comb begin
      busy_n  = busy_ff[cur_ff];
      cjob_n  = cjob_ff[cur_ff];
      left_n  = left_ff[cur_ff];
      slice_n = slice_ff[cur_ff];
      head_in = head_ff;
      tail_in = tail_ff;
      qcnt_in = qcnt_ff;
      q_we    = 1'b0;
      q_wdata = {id_ff, len_ff};
      ev_v = 1'b0;
      ev_k = mrrd_pkg::EV_TICK_DONE;
      ev_j = '0;
      free_after = free_cnt;
      pend_in = 1'b0;
      pend_job_in = pend_job_ff;
      pend_free_in = pend_free_ff;
      pend_q_in = pend_q_ff;
      fin = 1'b0; disp = 1'b0; expired = 1'b0;
      left_dec = left_n - LW'(1);
      if (cmd.do_add) begin
         ev_v = 1'b1;
         ev_j = id_ff;
         if ((32'(qcnt_ff) + 32'(run_cnt) + 1) <= QUEUE_DEPTH) begin
            ev_k = mrrd_pkg::EV_ACCEPTED;
            q_we = 1'b1;
            tail_in = nxt(tail_ff);
            qcnt_in = qcnt_ff + QC_W'(1);
         end else begin
            ev_k = mrrd_pkg::EV_REJECTED;
         end
      end else if (cmd.do_assign) begin
         // free_cnt is unchanged by retiring (finished job already counts free)
         fin = busy_ff[cur_ff] && left_ff[cur_ff] == '0;
         if (fin) busy_n = 1'b0;
         disp = (!busy_ff[cur_ff] || fin) && qcnt_ff != '0;
         if (disp) begin
            cjob_n  = q_rd_ff[JW+LW-1:LW];
            left_n  = q_rd_ff[LW-1:0];
            slice_n = quantum_ff;
            busy_n  = 1'b1;
            head_in = nxt(head_ff);
            qcnt_in = qcnt_ff - QC_W'(1);
         end
         if (disp && q_rd_ff[LW-1:0] != '0) free_after = free_cnt - CC_W'(1);
         if (fin) begin
            ev_v = 1'b1;
            ev_k = mrrd_pkg::EV_FINISHED;
            ev_j = cjob_ff[cur_ff];
            free_after = free_cnt;
            if (disp) begin
               pend_in = 1'b1;
               pend_job_in = q_rd_ff[JW+LW-1:LW];
               pend_free_in = (q_rd_ff[LW-1:0] != '0) ? free_cnt - CC_W'(1) : free_cnt;
               pend_q_in = qcnt_ff - QC_W'(1);
            end
         end else if (disp) begin
            ev_v = 1'b1;
            ev_k = mrrd_pkg::EV_DISPATCHED;
            ev_j = q_rd_ff[JW+LW-1:LW];
         end
      end else if (cmd.do_exec) begin
         if (busy_ff[cur_ff] && left_ff[cur_ff] != '0) begin
            left_n = left_dec;
            if (left_dec == '0) free_after = free_cnt + CC_W'(1);
            if (rr_mode_ff) begin
               expired = slice_ff[cur_ff] <= QW'(1);
               slice_n = expired ? '0 : slice_ff[cur_ff] - QW'(1);
               if (expired && left_dec != '0) begin
                  busy_n  = 1'b0;
                  free_after = free_cnt + CC_W'(1);
                  if (32'(qcnt_ff) < QUEUE_DEPTH) begin
                     q_we    = 1'b1;
                     q_wdata = {cjob_ff[cur_ff], left_dec};
                     tail_in = nxt(tail_ff);
                     qcnt_in = qcnt_ff + QC_W'(1);
                  end
                  ev_v = 1'b1;
                  ev_k = mrrd_pkg::EV_PREEMPTED;
                  ev_j = cjob_ff[cur_ff];
               end
            end
         end
      end else if (cmd.emit_tick) begin
         ev_v = 1'b1;
         ev_k = mrrd_pkg::EV_TICK_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         qcnt_ff <= '0;
         for (int c = 0; c < MAX_CORES; c++) busy_ff[c] <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         qcnt_ff <= qcnt_in;
         if (cmd.do_assign || cmd.do_exec) busy_ff[cur_ff] <= busy_n;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_assign || cmd.do_exec) begin
         cjob_ff[cur_ff]  <= cjob_n;
         left_ff[cur_ff]  <= left_n;
         slice_ff[cur_ff] <= slice_n;
      end
      if (q_we) q_mem[tail_ff] <= q_wdata;
      q_rd_ff <= q_mem[head_in];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.core_first) cur_ff <= '0;
      else if (cmd.core_next) cur_ff <= cur_ff + C_W'(1);
   end

   // result register plus one hold slot for dispatch after finish
   logic last_flag;
   assign last_flag = cmd.emit_tick || cmd.do_add;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         if (out_valid && out_ready) begin
            if (pend_ff) begin
               // core pointer holds while the walk waits on the result slot
               out_valid <= 1'b1;
               out_kind  <= mrrd_pkg::EV_DISPATCHED;
               out_job   <= pend_job_ff;
               out_core  <= mrrd_pkg::ECORE_W'(cur_ff);
               out_free  <= mrrd_pkg::FREE_W'(pend_free_ff);
               out_qcnt  <= mrrd_pkg::QCNT_W'(pend_q_ff);
               out_last  <= 1'b0;
               pend_ff   <= 1'b0;
            end else begin
               out_valid <= 1'b0;
            end
         end
         if (ev_v) begin
            out_valid <= 1'b1;
            out_kind  <= ev_k;
            out_job   <= ev_j;
            out_core  <= (cmd.do_add || cmd.emit_tick) ? '0 : mrrd_pkg::ECORE_W'(cur_ff);
            out_free  <= mrrd_pkg::FREE_W'(free_after);
            // finish ahead of a dispatch reports the queue before the pop
            out_qcnt  <= mrrd_pkg::QCNT_W'(pend_in ? qcnt_ff : qcnt_in);
            out_last  <= last_flag;
            pend_ff   <= pend_in;
            pend_job_ff  <= pend_job_in;
            pend_free_ff <= pend_free_in;
            pend_q_ff    <= pend_q_in;
         end
      end
   end

   assign sts.op_tick   = op_ff;
   assign sts.run_en    = run_en_ff;
   assign sts.no_active = act_sat == '0;
   assign sts.core_last = (32'(cur_ff) + 1) >= 32'(act_sat);
   assign sts.emit_busy = out_valid;

   initial_check: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= QC_W'(QUEUE_DEPTH))
      else $error("queue count over depth");
   no_emit_clobber: assert property (@(posedge clock) disable iff (reset)
      ev_v |-> !out_valid)
      else $error("result overwritten");
   q_count_ptr: assert property (@(posedge clock) disable iff (reset)
      (qcnt_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue pointers differ");
endmodule

FILE: rtl/mrrd_ctrl.sv
// ----------------------------------------------------------------------------
// mrrd_ctrl
// Sequencer: add, or per-core assign walk then execute walk, then tick done.
// ----------------------------------------------------------------------------
module mrrd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output mrrd_pkg::cmd_type cmd,
   input  mrrd_pkg::sts_type sts
);
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_ASSIGN = 6'b000100,
      S_EXEC   = 6'b001000,
      S_DONE   = 6'b010000,
      S_WAIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      in_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load_item = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.core_first = 1'b1;
            if (!sts.emit_busy) begin
               if (!sts.op_tick) begin
                  cmd.do_add = 1'b1;
                  state_in = S_IDLE;
               end else if (!sts.run_en || sts.no_active) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_ASSIGN;
               end
            end
         end
         S_ASSIGN: begin
            if (!sts.emit_busy) begin
               cmd.do_assign = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // queue read settles after a pop; result slot drains
            if (!sts.emit_busy) begin
               if (sts.core_last) begin
                  cmd.core_first = 1'b1;
                  state_in = S_EXEC;
               end else begin
                  cmd.core_next = 1'b1;
                  state_in = S_ASSIGN;
               end
            end
         end
         S_EXEC: begin
            if (!sts.emit_busy) begin
               cmd.do_exec = 1'b1;
               if (sts.core_last) state_in = S_DONE;
               else cmd.core_next = 1'b1;
            end
         end
         S_DONE: begin
            if (!sts.emit_busy) begin
               cmd.emit_tick = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   one_step: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.do_add, cmd.do_assign, cmd.do_exec, cmd.emit_tick}) <= 1)
      else $error("several datapath steps at once");
   accept_idle: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> state_ff == S_DECODE)
      else $error("accepted item not decoded");
   busy_hold: assert property (@(posedge clock) disable iff (reset)
      sts.emit_busy |-> !(cmd.do_add || cmd.do_assign || cmd.do_exec || cmd.emit_tick))
      else $error("step while result held");
endmodule

FILE: rtl/multicore_round_robin_dispatcher.sv
// ----------------------------------------------------------------------------
// multicore_round_robin_dispatcher
// Job dispatcher: ready FIFO, per-core run state, FCFS or round robin.
// ----------------------------------------------------------------------------
// Add: the item is accepted in idle, then decode runs the admission test, pushes the
// item if admitted and registers its result; the block then returns to idle. Tick over
// N active cores: decode, then per core an assign step and a wait step, then per core an
// execute step, then tick done (decode goes straight to tick done when disabled or with
// no active core). Every earlier result holds the walk until the consumer takes it (single result register).
// One item at a time. Synchronous active-high reset empties the queue, idles
// every core and loads the register defaults; no clearing pass.
module multicore_round_robin_dispatcher #(
   parameter int MAX_CORES   = mrrd_pkg::MAX_CORES_DEF,
   parameter int QUEUE_DEPTH = mrrd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // job_id[7:0], job_length[23:8]
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // event_kind, event_job, event_core, free_cores, queue_count
   output logic        rsp_tlast,   // last_event
   input  logic        csr_we,
   input  logic [mrrd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mrrd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   mrrd_pkg::cmd_type cmd;
   mrrd_pkg::sts_type sts;
   logic [mrrd_pkg::KIND_W-1:0]  k;
   logic [mrrd_pkg::JOB_W-1:0]   j;
   logic [mrrd_pkg::ECORE_W-1:0] c;
   logic [mrrd_pkg::FREE_W-1:0]  f;
   logic [mrrd_pkg::QCNT_W-1:0]  q;

   mrrd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .cmd(cmd), .sts(sts)
   );

   mrrd_datapath #(.MAX_CORES(MAX_CORES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .item_op(req_tuser), .item_job(req_tdata[7:0]), .item_len(req_tdata[23:8]),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_kind(k), .out_job(j), .out_core(c), .out_free(f), .out_qcnt(q),
      .out_last(rsp_tlast)
   );

   assign rsp_tdata = {3'b000, q, f, c, j, k};
endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multicore round-robin dispatcher: directed job
// and tick sequences, then random traffic under several scheduler settings,
// with every result compared against an in-bench scheduler prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NCORES = mrrd_pkg::MAX_CORES_DEF;
   localparam int QDEPTH = mrrd_pkg::QUEUE_DEPTH_DEF;

   typedef struct packed {
      logic [mrrd_pkg::QCNT_W-1:0]  qcnt;
      logic [mrrd_pkg::FREE_W-1:0]  free;
      logic [mrrd_pkg::ECORE_W-1:0] core;
      logic [mrrd_pkg::JOB_W-1:0]   job;
      logic [mrrd_pkg::KIND_W-1:0]  kind;
      logic                         last;
   } event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [mrrd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mrrd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   multicore_round_robin_dispatcher u_dut (.*);

   always #5 clock = ~clock;

   // scheduler state as predicted
   logic [mrrd_pkg::JOB_W-1:0] fifo_id [QDEPTH];
   logic [mrrd_pkg::LEN_W-1:0] fifo_len [QDEPTH];
   int                         fifo_head, fifo_tail, fifo_count;
   logic                       busy [NCORES];
   logic [mrrd_pkg::JOB_W-1:0] run_job [NCORES];
   logic [mrrd_pkg::LEN_W-1:0] run_left [NCORES];
   logic [mrrd_pkg::QNT_W-1:0] run_slice [NCORES];
   logic                       rr_mode;
   logic [mrrd_pkg::QNT_W-1:0] quantum;
   logic [mrrd_pkg::ACT_W-1:0] active;
   logic                       run_en;

   event_type pending_events[$];
   int        errors = 0;
   int        n_items = 0, n_events = 0, n_preempt = 0, n_reject = 0;

   function automatic int free_count();
      int n = 0;
      for (int c = 0; c < NCORES; c++) if (!busy[c] || run_left[c] == 0) n++;
      return n;
   endfunction

   function automatic int running_count();
      return NCORES - free_count();
   endfunction

   function automatic void push_event(logic [mrrd_pkg::KIND_W-1:0] k,
                                      logic [mrrd_pkg::JOB_W-1:0] j, int c);
      event_type e;
      e.kind = k; e.job = j; e.core = c[mrrd_pkg::ECORE_W-1:0];
      e.free = mrrd_pkg::FREE_W'(free_count());
      e.qcnt = fifo_count[mrrd_pkg::QCNT_W-1:0]; e.last = 1'b0;
      pending_events.push_back(e);
   endfunction

   function automatic void fifo_push(logic [mrrd_pkg::JOB_W-1:0] id,
                                     logic [mrrd_pkg::LEN_W-1:0] len);
      fifo_id[fifo_tail] = id; fifo_len[fifo_tail] = len;
      fifo_tail = (fifo_tail + 1) % QDEPTH;
      fifo_count++;
   endfunction

   function automatic void predict_schedule(logic op, logic [mrrd_pkg::JOB_W-1:0] id,
                                            logic [mrrd_pkg::LEN_W-1:0] len);
      int act;
      event_type e;
      if (op == mrrd_pkg::OP_ADD) begin
         if (fifo_count + running_count() + 1 <= QDEPTH) begin
            fifo_push(id, len);
            push_event(mrrd_pkg::EV_ACCEPTED, id, 0);
         end else begin
            n_reject++;
            push_event(mrrd_pkg::EV_REJECTED, id, 0);
         end
      end else if (run_en) begin
         act = (active > NCORES) ? NCORES : active;
         for (int c = 0; c < act; c++) begin
            if (busy[c] && run_left[c] == 0) begin
               busy[c] = 1'b0;
               push_event(mrrd_pkg::EV_FINISHED, run_job[c], c);
            end
            if (!busy[c] && fifo_count != 0) begin
               run_job[c] = fifo_id[fifo_head];
               run_left[c] = fifo_len[fifo_head];
               fifo_head = (fifo_head + 1) % QDEPTH;
               fifo_count--;
               run_slice[c] = quantum;
               busy[c] = 1'b1;
               push_event(mrrd_pkg::EV_DISPATCHED, run_job[c], c);
            end
         end
         for (int c = 0; c < act; c++) begin
            if (busy[c] && run_left[c] != 0) begin
               run_left[c]--;
               if (rr_mode) begin
                  if (run_slice[c] <= 1) begin
                     run_slice[c] = '0;
                     if (run_left[c] != 0) begin
                        busy[c] = 1'b0;
                        if (fifo_count < QDEPTH) fifo_push(run_job[c], run_left[c]);
                        n_preempt++;
                        push_event(mrrd_pkg::EV_PREEMPTED, run_job[c], c);
                     end
                  end else run_slice[c]--;
               end
            end
         end
         push_event(mrrd_pkg::EV_TICK_DONE, '0, 0);
      end else push_event(mrrd_pkg::EV_TICK_DONE, '0, 0);
      e = pending_events[$];
      e.last = 1'b1;
      pending_events[$] = e;
   endfunction

   // result side: random stalls, compare each transfer with oldest expectation
   int stall_left = 0;
   always @(posedge clock) begin
      event_type exp_e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_events++;
            if (pending_events.size() == 0) begin
               $error("unexpected result %h last %b", rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               exp_e = pending_events.pop_front();
               if (rsp_tdata[2:0] !== exp_e.kind) begin
                  $error("event_kind exp %0d got %0d", exp_e.kind, rsp_tdata[2:0]); errors++;
               end
               if (rsp_tdata[10:3] !== exp_e.job) begin
                  $error("event_job exp %0d got %0d", exp_e.job, rsp_tdata[10:3]); errors++;
               end
               if (rsp_tdata[12:11] !== exp_e.core) begin
                  $error("event_core exp %0d got %0d", exp_e.core, rsp_tdata[12:11]);
                  errors++;
               end
               if (rsp_tdata[15:13] !== exp_e.free) begin
                  $error("free_cores exp %0d got %0d", exp_e.free, rsp_tdata[15:13]);
                  errors++;
               end
               if (rsp_tdata[20:16] !== exp_e.qcnt) begin
                  $error("queue_count exp %0d got %0d", exp_e.qcnt, rsp_tdata[20:16]);
                  errors++;
               end
               if (rsp_tlast !== exp_e.last) begin
                  $error("last_event exp %0d got %0d", exp_e.last, rsp_tlast); errors++;
               end
            end
         end
         // draw a fresh wait after each transfer; idle spells off in some stretches
         if (rsp_tvalid && rsp_tready) begin
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            rsp_tready <= (stall_left == 0);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= (stall_left == 0);
         end else rsp_tready <= 1'b1;
      end
   end

   // valid stays up across back-to-back items; the block is busy right after a transfer
   task automatic send_item(logic op, logic [mrrd_pkg::JOB_W-1:0] id,
                            logic [mrrd_pkg::LEN_W-1:0] len, bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {len, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_schedule(op, id, len);
      n_items++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [mrrd_pkg::CSR_IDX_W-1:0] idx,
                            logic [mrrd_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      case (idx)
         mrrd_pkg::CSR_RR_MODE: rr_mode = val[0];
         mrrd_pkg::CSR_QUANTUM: quantum = val;
         mrrd_pkg::CSR_ACTIVE:  active  = val[mrrd_pkg::ACT_W-1:0];
         mrrd_pkg::CSR_RUN_EN:  run_en  = val[0];
         default: ;
      endcase
   endtask

   task automatic configure(logic rr, logic [mrrd_pkg::QNT_W-1:0] q,
                            logic [mrrd_pkg::ACT_W-1:0] a, logic en);
      drain();
      write_reg(mrrd_pkg::CSR_RR_MODE, mrrd_pkg::CSR_DATA_W'(rr));
      write_reg(mrrd_pkg::CSR_QUANTUM, q);
      write_reg(mrrd_pkg::CSR_ACTIVE, mrrd_pkg::CSR_DATA_W'(a));
      write_reg(mrrd_pkg::CSR_RUN_EN, mrrd_pkg::CSR_DATA_W'(en));
      csr_we <= 1'b0;
   endtask

   task automatic test_directed_fcfs();
      send_item(mrrd_pkg::OP_ADD, 8'hFF, 16'hFFFF);
      send_item(mrrd_pkg::OP_ADD, 8'h00, 16'h0000);   // zero-length job
      send_item(mrrd_pkg::OP_ADD, 8'hA5, 16'h0001);
      send_item(mrrd_pkg::OP_ADD, 8'h5A, 16'h0002);
      send_item(mrrd_pkg::OP_ADD, 8'h81, 16'h8000);
      repeat (4) send_item(mrrd_pkg::OP_TICK, 8'h00, 16'h0000);
      send_item(mrrd_pkg::OP_TICK, 8'hFF, 16'hFFFF);   // tick ignores payload
      // fill up to the admission limit, then one more is rejected
      for (int i = 0; i < 15; i++)
         send_item(mrrd_pkg::OP_ADD, i[7:0] + 8'h10, 16'd3, 0);
   endtask

   task automatic test_rr_quantum_one();
      configure(1'b1, 16'd0, 3'd2, 1'b1);   // zero quantum acts as one
      repeat (10) send_item(mrrd_pkg::OP_TICK, 8'h00, 16'h0000);
   endtask

   task automatic test_disabled_and_odd_cores();
      configure(1'b0, 16'hFFFF, 3'd0, 1'b1);   // no active cores
      send_item(mrrd_pkg::OP_TICK, 8'h00, 16'h0000);
      configure(1'b0, 16'hFFFF, 3'd7, 1'b0);   // saturating count, disabled
      send_item(mrrd_pkg::OP_ADD, 8'h42, 16'd5);
      send_item(mrrd_pkg::OP_TICK, 8'h00, 16'h0000);
      configure(1'b0, 16'hFFFF, 3'd7, 1'b1);
      repeat (30) send_item(mrrd_pkg::OP_TICK, 8'h00, 16'h0000);
   endtask

   task automatic random_phase(int count, int tick_pct, int max_len);
      logic [mrrd_pkg::LEN_W-1:0] len;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < tick_pct)
            send_item(mrrd_pkg::OP_TICK, mrrd_pkg::JOB_W'($urandom),
                      mrrd_pkg::LEN_W'($urandom));
         else begin
            len = ($urandom_range(0, 19) == 0) ? mrrd_pkg::LEN_W'($urandom)
                                              : mrrd_pkg::LEN_W'($urandom_range(0, max_len));
            send_item(mrrd_pkg::OP_ADD, mrrd_pkg::JOB_W'($urandom), len,
                      1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic test_random();
      configure(1'b1, 16'd2, 3'd4, 1'b1);
      random_phase(70, 55, 8);
      configure(1'b1, 16'd1, 3'd3, 1'b1);
      random_phase(50, 60, 6);
      configure(1'b0, 16'd5, 3'd1, 1'b1);
      random_phase(40, 50, 4);
      configure(1'b1, 16'd3, 3'd4, 1'b1);
      random_phase(50, 65, 10);
      configure(1'b1, 16'hFFFF, 3'd4, 1'b0);
      random_phase(10, 50, 10);
      configure(1'b1, 16'd4, 3'd4, 1'b1);
      random_phase(25, 70, 10);
   endtask

   initial begin
      fifo_head = 0; fifo_tail = 0; fifo_count = 0;
      for (int c = 0; c < NCORES; c++) begin
         busy[c] = 1'b0; run_job[c] = '0; run_left[c] = '0; run_slice[c] = '0;
      end
      rr_mode = 1'b0; quantum = 16'd1; active = 3'd4; run_en = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_fcfs();
      test_rr_quantum_one();
      test_disabled_and_odd_cores();
      test_random();
      drain();
      $display("Sent %0d items, checked %0d results (%0d preemptions, %0d rejects)",
               n_items, n_events, n_preempt, n_reject);
      if (errors == 0) $display("multicore_round_robin_dispatcher test passed");
      else $display("multicore_round_robin_dispatcher test failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("multicore_round_robin_dispatcher test failed");
      $finish;
   end
endmodule

FILE: multicore_round_robin_dispatcher.f
rtl/mrrd_pkg.sv
rtl/mrrd_datapath.sv
rtl/mrrd_ctrl.sv
rtl/multicore_round_robin_dispatcher.sv
tb/sv/tb_top.sv
